### sv/hevc_annexb_nal_header_parser_defines.svh
// Assertion macros for the NAL header parser.
`ifndef HEVC_ANNEXB_NAL_HEADER_PARSER_DEFINES_SVH
`define HEVC_ANNEXB_NAL_HEADER_PARSER_DEFINES_SVH

`ifndef SYNTH
`define HNHP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("nal header parser check failed");
`define HNHP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nal header parser check failed");
`else
`define HNHP_ASSERT(lbl, prop)
`define HNHP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### sv/hnhp_pkg.sv
package hnhp_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int PAYLOAD_W   = 24;
  localparam int HDR_END_W   = 16;

  localparam logic [3:0] PH_HDR0  = 4'd0;
  localparam logic [3:0] PH_HDR1  = 4'd1;
  localparam logic [3:0] PH_FIRST = 4'd2;
  localparam logic [3:0] PH_NOOUT = 4'd3;
  localparam logic [3:0] PH_PPS_Z = 4'd4;
  localparam logic [3:0] PH_PPS_S = 4'd5;
  localparam logic [3:0] PH_ST_Z  = 4'd6;
  localparam logic [3:0] PH_ST_S  = 4'd7;
  localparam logic [3:0] PH_POC   = 4'd8;
  localparam logic [3:0] PH_DONE  = 4'd9;

  localparam logic [1:0] KIND_PSET  = 2'd0;
  localparam logic [1:0] KIND_SLICE = 2'd1;
  localparam logic [1:0] KIND_ERR   = 2'd2;

  localparam logic [1:0] FT_I   = 2'd0;
  localparam logic [1:0] FT_P   = 2'd1;
  localparam logic [1:0] FT_B   = 2'd2;
  localparam logic [1:0] FT_UNK = 2'd3;

  localparam logic [4:0] POC_BITS_RESET = 5'd8;
  localparam logic [4:0] POC_BITS_MIN   = 5'd4;
  localparam logic [4:0] POC_BITS_MAX   = 5'd16;

  localparam logic [5:0] TYPE_IRAP_LO = 6'd16;
  localparam logic [5:0] TYPE_IRAP_HI = 6'd23;
  localparam logic [5:0] TYPE_IDR_A   = 6'd19;
  localparam logic [5:0] TYPE_IDR_B   = 6'd20;
  localparam logic [5:0] TYPE_PS_LO   = 6'd32;
  localparam logic [5:0] TYPE_PS_HI   = 6'd34;

  localparam logic [5:0] GOLOMB_ZERO_MAX = 6'd32;

  typedef struct packed {
    logic [3:0]  phase;
    logic [5:0]  bcnt;
    logic [15:0] acc;
    logic        big;
    logic [1:0]  stype;
    logic        err;
  } bit_st_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [5:0]           ntype;
    logic [1:0]           ft;
    logic [15:0]          poc;
    logic [PAYLOAD_W-1:0] len;
  } result_t;

  function automatic bit_st_t ue_done(bit_st_t s, logic [1:0] st, logic idr,
                                      logic [5:0] poc_n);
    bit_st_t r;
    r = s;
    if (s.phase == PH_PPS_Z || s.phase == PH_PPS_S) begin
      r.phase = PH_ST_Z;
      r.bcnt  = 6'd0;
    end else begin
      r.stype = st;
      if (idr) begin
        r.phase = PH_DONE;
      end else begin
        r.phase = PH_POC;
        r.bcnt  = poc_n;
        r.acc   = 16'd0;
      end
    end
    return r;
  endfunction

  function automatic bit_st_t feed_bit(bit_st_t s, logic b, logic irap, logic idr,
                                       logic [5:0] poc_n);
    bit_st_t     r;
    logic [5:0]  bc_inc;
    logic [5:0]  bc_dec;
    logic [15:0] acc_sh;
    logic [1:0]  st_s;
    r      = s;
    bc_inc = s.bcnt + 6'd1;
    bc_dec = s.bcnt - 6'd1;
    acc_sh = {s.acc[14:0], b};
    // a one-zero code accumulates 2 or 3 (value 1 or 2); longer codes give values above 2
    st_s   = s.big ? FT_UNK : (acc_sh[0] ? FT_I : FT_P);
    unique case (s.phase) inside
      PH_FIRST: begin
        if (!b) begin
          r.err   = 1'b1;
          r.phase = PH_DONE;
        end else begin
          r.phase = irap ? PH_NOOUT : PH_PPS_Z;
          r.bcnt  = 6'd0;
        end
      end
      PH_NOOUT: begin
        r.phase = PH_PPS_Z;
        r.bcnt  = 6'd0;
      end
      PH_PPS_Z, PH_ST_Z: begin
        if (!b) begin
          r.bcnt = bc_inc;
          if (bc_inc >= GOLOMB_ZERO_MAX) begin
            r.err   = 1'b1;
            r.phase = PH_DONE;
          end
        end else if (s.bcnt == 6'd0) begin
          r = ue_done(s, FT_B, idr, poc_n);
        end else begin
          r.acc   = 16'd1;
          r.big   = (s.bcnt >= 6'd2);
          r.phase = s.phase + 4'd1;
        end
      end
      PH_PPS_S, PH_ST_S: begin
        r.acc  = acc_sh;
        r.bcnt = bc_dec;
        if (bc_dec == 6'd0) begin
          r = ue_done(r, st_s, idr, poc_n);
        end
      end
      PH_POC: begin
        r.acc  = acc_sh;
        r.bcnt = bc_dec;
        if (bc_dec == 6'd0) begin
          r.phase = PH_DONE;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

endpackage

### sv/hevc_annexb_nal_header_parser.sv
// Channel | Dir | Fields (lowest bit first)
// s_*     | in  | tdata: data_byte[7:0]; tlast: end_of_stream
// m_*     | out | tdata: nal_type, frame_type, poc_lsb, payload_length; tuser: nal_kind
// cfg_*   | in  | wr_data: poc_lsb_bits[4:0]
//
// One byte per cycle unless stalled: start-code search, length count and the eight-bit
// header bit walk all settle in one step from the state registers back to themselves.
// Results go through a two-entry output queue; s_tready drops only while both are full.
// rst is synchronous, active high; after it the parser waits for the first start code.
`include "hevc_annexb_nal_header_parser_defines.svh"

module hevc_annexb_nal_header_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // nal_type[5:0], frame_type[7:6], poc_lsb[23:8],
                                 // payload_length[47:24]
  output logic [1:0]  m_tuser,   // nal_kind[1:0]
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int CW = hnhp_pkg::LENGTH_BITS;
  localparam int HW = hnhp_pkg::HDR_END_W;
  localparam int PW = hnhp_pkg::PAYLOAD_W;

  logic [4:0]          poc_bits;
  logic [23:0]         window;
  logic                in_unit;
  logic [CW-1:0]       count;
  hnhp_pkg::bit_st_t   st;
  logic [5:0]          ntype;
  logic [HW-1:0]       hdr_end;
  logic                v0, v1;
  hnhp_pkg::result_t   r0, r1;

  logic [23:0]         window_next;
  logic                in_unit_next;
  logic [CW-1:0]       count_next;
  hnhp_pkg::bit_st_t   st_next;
  logic [5:0]          ntype_next;
  logic                hdr_end_load;

  logic [7:0]          x;
  logic                accept, sc, epb, emit, pop, irap, idr, pset, done_ok;
  logic [CW-1:0]       len, len_sc, trail;
  logic [HW-1:0]       used;
  logic [5:0]          poc_n;
  hnhp_pkg::bit_st_t   st_fed, st_clr;
  logic [5:0]          ntype_fed;
  hnhp_pkg::result_t   res;

  assign x        = s_tdata;
  assign accept   = s_tvalid && s_tready;
  assign s_tready = !v1;
  assign pop      = v0 && m_tready;
  assign m_tvalid = v0;
  assign m_tuser  = r0.kind;
  assign m_tdata  = {r0.len, r0.poc, r0.ft, r0.ntype};

  always_comb begin
    sc   = (x == 8'h01) && (window[7:0] == 8'h00) && (window[15:8] == 8'h00);
    epb  = (count >= CW'(2)) && (x == 8'h03) && (window[7:0] == 8'h00) &&
           (window[15:8] == 8'h00);
    irap = (ntype >= hnhp_pkg::TYPE_IRAP_LO) && (ntype <= hnhp_pkg::TYPE_IRAP_HI);
    idr  = (ntype == hnhp_pkg::TYPE_IDR_A) || (ntype == hnhp_pkg::TYPE_IDR_B);
    pset = (ntype >= hnhp_pkg::TYPE_PS_LO) && (ntype <= hnhp_pkg::TYPE_PS_HI);

    if (poc_bits < hnhp_pkg::POC_BITS_MIN) begin
      poc_n = 6'(hnhp_pkg::POC_BITS_MIN);
    end else if (poc_bits > hnhp_pkg::POC_BITS_MAX) begin
      poc_n = 6'(hnhp_pkg::POC_BITS_MAX);
    end else begin
      poc_n = 6'(poc_bits);
    end

    // length of the closing unit, trailing start code removed unless saturated
    trail = (window[23:16] == 8'h00) ? CW'(3) : CW'(2);
    if (count == '1) begin
      len_sc = count;
    end else if (count >= trail) begin
      len_sc = count - trail;
    end else begin
      len_sc = '0;
    end
    len  = s_tlast ? count : len_sc;
    emit = accept && in_unit && (s_tlast || sc) && (len != '0);

    done_ok = (st.phase == hnhp_pkg::PH_DONE) && !st.err &&
              (33'(hdr_end) <= 33'(len));
    res.ntype = ntype;
    res.len   = (33'(len) > 33'({PW{1'b1}})) ? {PW{1'b1}} : PW'(len);
    if (!done_ok) begin
      res.kind = hnhp_pkg::KIND_ERR;
      res.ft   = hnhp_pkg::FT_UNK;
      res.poc  = 16'd0;
    end else if (pset) begin
      res.kind = hnhp_pkg::KIND_PSET;
      res.ft   = hnhp_pkg::FT_UNK;
      res.poc  = 16'd0;
    end else begin
      res.kind = hnhp_pkg::KIND_SLICE;
      res.ft   = st.stype;
      res.poc  = idr ? 16'd0 : st.acc;
    end

    used = (33'(count) < 33'({HW{1'b1}})) ? HW'(count + CW'(1)) : {HW{1'b1}};

    st_fed    = st;
    ntype_fed = ntype;
    if (st.phase == hnhp_pkg::PH_HDR0) begin
      ntype_fed    = x[6:1];
      st_fed.phase = hnhp_pkg::PH_HDR1;
    end else if (st.phase == hnhp_pkg::PH_HDR1) begin
      if (pset) begin
        st_fed.phase = hnhp_pkg::PH_DONE;
      end else if (ntype > hnhp_pkg::TYPE_PS_HI) begin
        st_fed.phase = hnhp_pkg::PH_DONE;
        st_fed.err   = 1'b1;
      end else begin
        st_fed.phase = hnhp_pkg::PH_FIRST;
      end
    end else begin
      for (int b = 7; b >= 0; b--) begin
        st_fed = hnhp_pkg::feed_bit(st_fed, x[3'(b)], irap, idr, poc_n);
      end
    end

    st_clr.phase = hnhp_pkg::PH_HDR0;
    st_clr.bcnt  = 6'd0;
    st_clr.acc   = 16'd0;
    st_clr.big   = 1'b0;
    st_clr.stype = hnhp_pkg::FT_UNK;
    st_clr.err   = 1'b0;

    window_next  = {window[15:0], x};
    in_unit_next = in_unit;
    count_next   = count;
    st_next      = st;
    ntype_next   = ntype;
    hdr_end_load = 1'b0;
    if (s_tlast) begin
      window_next  = '1;
      in_unit_next = 1'b0;
      count_next   = '0;
      st_next      = st_clr;
      ntype_next   = 6'd0;
    end else if (sc) begin
      in_unit_next = 1'b1;
      count_next   = '0;
      st_next      = st_clr;
      ntype_next   = 6'd0;
    end else if (in_unit) begin
      if (count != '1) begin
        count_next = count + CW'(1);
      end
      if (!epb && st.phase != hnhp_pkg::PH_DONE) begin
        st_next      = st_fed;
        ntype_next   = ntype_fed;
        hdr_end_load = (st_fed.phase == hnhp_pkg::PH_DONE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poc_bits <= hnhp_pkg::POC_BITS_RESET;
      window   <= '1;
      in_unit  <= 1'b0;
      count    <= '0;
      st.phase <= hnhp_pkg::PH_HDR0;
      st.bcnt  <= 6'd0;
      st.acc   <= 16'd0;
      st.big   <= 1'b0;
      st.stype <= hnhp_pkg::FT_UNK;
      st.err   <= 1'b0;
      ntype    <= 6'd0;
      v0       <= 1'b0;
      v1       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        poc_bits <= cfg_wr_data;
      end
      if (accept) begin
        window  <= window_next;
        in_unit <= in_unit_next;
        count   <= count_next;
        st      <= st_next;
        ntype   <= ntype_next;
      end
      if (pop) begin
        v0 <= v1 || emit;
        v1 <= 1'b0;
      end else if (emit) begin
        v0 <= 1'b1;
        v1 <= v0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hdr_end_load) begin
      hdr_end <= used;
    end
    if (pop) begin
      r0 <= v1 ? r1 : res;
    end else if (emit) begin
      if (v0) begin
        r1 <= res;
      end else begin
        r0 <= res;
      end
    end
  end

  `HNHP_ASSERT_ALWAYS(a_queue_order, !v1 || v0 || rst)
  `HNHP_ASSERT(a_eos_clears, (accept && s_tlast) |=> (!in_unit && (window == 24'hFFFFFF)))
  `HNHP_ASSERT(a_hdr_end_bound, (st.phase == hnhp_pkg::PH_DONE) |->
    (33'(hdr_end) <= 33'(count)))
  `HNHP_ASSERT(a_err_done, st.err |-> (st.phase == hnhp_pkg::PH_DONE))

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  ntype;
    logic [1:0]  ft;
    logic [15:0] poc;
    logic [23:0] len;
  } nal_res_t;

  typedef struct packed {
    logic       eos;
    logic [7:0] data;
    logic       typed;
    nal_res_t   res;
  } word_row_t;

  localparam nal_res_t NO_NAL = '0;
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;
  localparam logic [7:0] EPB     = 8'h03;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;

  hevc_annexb_nal_header_parser uut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  // parser state mirror
  logic [4:0]  poc_cfg;
  logic [23:0] win;
  logic        in_unit;
  logic [23:0] cnt;
  logic [3:0]  phase;
  logic [5:0]  zbits;
  logic [31:0] acc;
  logic [5:0]  h_type;
  logic [1:0]  h_st;
  logic [15:0] h_poc;
  logic        h_err;

  nal_res_t  pending_nals[$];
  bit        hdr_bits[$];
  word_row_t dir_rows [25];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int sink_hold = 0;
  int mismatches = 0;
  int words_sent = 0;
  int eos_sent = 0;
  int nals_seen = 0;
  int cfg_writes = 0;
  int in_stalls = 0;

  task automatic unit_clear();
    cnt = '0;
    phase = hnhp_pkg::PH_HDR0;
    zbits = '0;
    acc = '0;
    h_type = '0;
    h_st = hnhp_pkg::FT_UNK;
    h_poc = '0;
    h_err = 1'b0;
  endtask

  task automatic nal_reset();
    poc_cfg = hnhp_pkg::POC_BITS_RESET;
    win = '1;
    in_unit = 1'b0;
    unit_clear();
  endtask

  // header done; acc keeps the byte count the header used
  task automatic hdr_end(input logic [31:0] used, input logic bad);
    if (bad) h_err = 1'b1;
    phase = hnhp_pkg::PH_DONE;
    acc = used;
  endtask

  task automatic golomb_end(input logic [31:0] v, input logic [31:0] used);
    logic [4:0] n;
    if (phase == hnhp_pkg::PH_PPS_Z || phase == hnhp_pkg::PH_PPS_S) begin
      phase = hnhp_pkg::PH_ST_Z;
      zbits = '0;
    end else begin
      case (v)
        32'd0: h_st = hnhp_pkg::FT_B;
        32'd1: h_st = hnhp_pkg::FT_P;
        32'd2: h_st = hnhp_pkg::FT_I;
        default: h_st = hnhp_pkg::FT_UNK;
      endcase
      if (h_type == hnhp_pkg::TYPE_IDR_A || h_type == hnhp_pkg::TYPE_IDR_B) begin
        h_poc = '0;
        hdr_end(used, 1'b0);
      end else begin
        n = poc_cfg;
        if (n < hnhp_pkg::POC_BITS_MIN) n = hnhp_pkg::POC_BITS_MIN;
        if (n > hnhp_pkg::POC_BITS_MAX) n = hnhp_pkg::POC_BITS_MAX;
        phase = hnhp_pkg::PH_POC;
        zbits = {1'b0, n};
        acc = '0;
      end
    end
  endtask

  task automatic take_bit(input logic b, input logic [31:0] used);
    case (phase) inside
      hnhp_pkg::PH_FIRST: begin
        if (!b) begin
          hdr_end(used, 1'b1);
        end else begin
          phase = (h_type >= hnhp_pkg::TYPE_IRAP_LO && h_type <= hnhp_pkg::TYPE_IRAP_HI) ?
                  hnhp_pkg::PH_NOOUT : hnhp_pkg::PH_PPS_Z;
          zbits = '0;
        end
      end
      hnhp_pkg::PH_NOOUT: begin
        phase = hnhp_pkg::PH_PPS_Z;
        zbits = '0;
      end
      hnhp_pkg::PH_PPS_Z, hnhp_pkg::PH_ST_Z: begin
        if (!b) begin
          zbits = zbits + 6'd1;
          if (zbits >= hnhp_pkg::GOLOMB_ZERO_MAX) hdr_end(used, 1'b1);
        end else if (zbits == 6'd0) begin
          golomb_end(32'd0, used);
        end else begin
          acc = 32'd1;
          phase = phase + 4'd1;
        end
      end
      hnhp_pkg::PH_PPS_S, hnhp_pkg::PH_ST_S: begin
        acc = {acc[30:0], b};
        zbits = zbits - 6'd1;
        if (zbits == 6'd0) golomb_end(acc - 32'd1, used);
      end
      hnhp_pkg::PH_POC: begin
        acc = {acc[30:0], b} & 32'hFFFF;
        zbits = zbits - 6'd1;
        if (zbits == 6'd0) begin
          h_poc = acc[15:0];
          hdr_end(used, 1'b0);
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic take_byte(input logic [7:0] x, input logic [31:0] used);
    int b;
    if (phase == hnhp_pkg::PH_HDR0) begin
      h_type = x[6:1];
      phase = hnhp_pkg::PH_HDR1;
    end else if (phase == hnhp_pkg::PH_HDR1) begin
      if (h_type >= hnhp_pkg::TYPE_PS_LO && h_type <= hnhp_pkg::TYPE_PS_HI)
        hdr_end(used, 1'b0);
      else if (h_type > hnhp_pkg::TYPE_PS_HI) hdr_end(used, 1'b1);
      else phase = hnhp_pkg::PH_FIRST;
    end else begin
      for (b = 7; b >= 0 && phase >= hnhp_pkg::PH_FIRST && phase < hnhp_pkg::PH_DONE; b--)
        take_bit(x[b], used);
    end
  endtask

  task automatic close_unit(input logic [23:0] len, output bit got, output nal_res_t r);
    r = '0;
    got = 0;
    if (len != 24'd0) begin
      got = 1;
      r.ntype = h_type;
      r.ft = hnhp_pkg::FT_UNK;
      r.len = len;
      if (phase != hnhp_pkg::PH_DONE || h_err || acc > {8'd0, len}) begin
        r.kind = hnhp_pkg::KIND_ERR;
      end else if (h_type >= hnhp_pkg::TYPE_PS_LO && h_type <= hnhp_pkg::TYPE_PS_HI) begin
        r.kind = hnhp_pkg::KIND_PSET;
      end else begin
        r.kind = hnhp_pkg::KIND_SLICE;
        r.ft = h_st;
        r.poc = h_poc;
      end
    end
  endtask

  task automatic nal_predict(input logic eos, input logic [7:0] x, output bit got,
                             output nal_res_t r);
    logic [23:0] len;
    logic [23:0] trail;
    logic [31:0] idx;
    logic        epb;
    got = 0;
    r = '0;
    if (eos) begin
      if (in_unit) close_unit(cnt, got, r);
      in_unit = 1'b0;
      win = '1;
      unit_clear();
    end else begin
      if (x == SC_ONE && win[15:0] == 16'h0000) begin
        if (in_unit) begin
          len = cnt;
          if (len != 24'hFFFFFF) begin
            trail = (win[23:16] == SC_ZERO) ? 24'd3 : 24'd2;
            len = (len >= trail) ? len - trail : 24'd0;
          end
          close_unit(len, got, r);
        end
        in_unit = 1'b1;
        unit_clear();
      end else if (in_unit) begin
        idx = {8'd0, cnt};
        epb = (idx >= 32'd2 && x == EPB && win[15:0] == 16'h0000);
        if (cnt != 24'hFFFFFF) cnt = cnt + 24'd1;
        if (!epb && phase < hnhp_pkg::PH_DONE)
          take_byte(x, (idx < 32'hFFFF) ? idx + 32'd1 : 32'hFFFF);
      end
      win = {win[15:0], x};
    end
  endtask

  task automatic send_word(input logic eos, input logic [7:0] d, input logic typed,
                           input nal_res_t want);
    bit       got;
    nal_res_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tlast <= eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    nal_predict(eos, d, got, r);
    words_sent++;
    if (eos) eos_sent++;
    if (typed) pending_nals.push_back(want);
    else if (got) pending_nals.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] d);
    send_word(1'b0, d, 1'b0, NO_NAL);
  endtask

  task automatic send_eos();
    send_word(1'b1, 8'($urandom), 1'b0, NO_NAL);
  endtask

  task automatic wait_nals_done();
    s_tvalid <= 1'b0;
    while (pending_nals.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [4:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    poc_cfg = v;
    cfg_writes++;
  endtask

  task automatic push_golomb(input logic [31:0] v);
    logic [32:0] c;
    int          nb;
    int          i;
    c = {1'b0, v} + 33'd1;
    nb = 0;
    while ((c >> (nb + 1)) != 0) nb++;
    repeat (nb) hdr_bits.push_back(1'b0);
    for (i = nb; i >= 0; i--) hdr_bits.push_back(c[i]);
  endtask

  // near and past the 32-zero limit
  task automatic push_long_golomb();
    int k;
    k = $urandom_range(29, 33);
    repeat (k) hdr_bits.push_back(1'b0);
    hdr_bits.push_back(1'b1);
    repeat (k) hdr_bits.push_back(1'($urandom));
  endtask

  task automatic send_unit(input int tail_max);
    logic [7:0]  raw[$];
    logic [7:0]  b;
    logic [5:0]  t;
    logic [4:0]  n;
    logic [15:0] last2;
    int          r;
    int          k;
    int          i;
    int          keep;
    if ($urandom_range(0, 2) == 0) send_byte(SC_ZERO);
    send_byte(SC_ZERO);
    send_byte(SC_ZERO);
    send_byte(SC_ONE);
    r = $urandom_range(0, 99);
    if (r < 30) t = 6'($urandom_range(0, 9));
    else if (r < 50)
      t = 6'($urandom_range(hnhp_pkg::TYPE_IRAP_LO, hnhp_pkg::TYPE_IRAP_HI));
    else if (r < 62)
      t = ($urandom_range(0, 1) != 0) ? hnhp_pkg::TYPE_IDR_A : hnhp_pkg::TYPE_IDR_B;
    else if (r < 78) t = 6'($urandom_range(hnhp_pkg::TYPE_PS_LO, hnhp_pkg::TYPE_PS_HI));
    else t = 6'($urandom_range(0, 63));
    raw.push_back({1'($urandom_range(0, 9) == 0), t, 1'($urandom)});
    raw.push_back(8'($urandom));
    if (t < hnhp_pkg::TYPE_PS_LO) begin
      hdr_bits.delete();
      hdr_bits.push_back($urandom_range(0, 9) != 0);
      if (t >= hnhp_pkg::TYPE_IRAP_LO && t <= hnhp_pkg::TYPE_IRAP_HI)
        hdr_bits.push_back(1'($urandom));
      if ($urandom_range(0, 19) == 0) push_long_golomb();
      else push_golomb(($urandom_range(0, 7) == 0) ? $urandom_range(4, 63) : $urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 28) push_golomb(32'd0);
      else if (r < 54) push_golomb(32'd1);
      else if (r < 78) push_golomb(32'd2);
      else if (r < 90) push_golomb($urandom_range(3, 40));
      else push_long_golomb();
      if (t != hnhp_pkg::TYPE_IDR_A && t != hnhp_pkg::TYPE_IDR_B) begin
        n = poc_cfg;
        if (n < hnhp_pkg::POC_BITS_MIN) n = hnhp_pkg::POC_BITS_MIN;
        if (n > hnhp_pkg::POC_BITS_MAX) n = hnhp_pkg::POC_BITS_MAX;
        repeat (n) hdr_bits.push_back(1'($urandom));
      end
      hdr_bits.push_back(1'b1);
      while (hdr_bits.size() % 8 != 0) hdr_bits.push_back(1'b0);
      for (k = 0; k < hdr_bits.size(); k += 8) begin
        b = '0;
        for (i = 0; i < 8; i++) b = {b[6:0], hdr_bits[k + i]};
        raw.push_back(b);
      end
    end
    k = $urandom_range(0, tail_max);
    repeat (k) begin
      r = $urandom_range(0, 99);
      if (r < 30) raw.push_back(SC_ZERO);
      else if (r < 40) raw.push_back(EPB);
      else if (r < 45) raw.push_back(SC_ONE);
      else raw.push_back(8'($urandom));
    end
    // truncated units, empty ones included
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(0, raw.size());
      while (raw.size() > keep) void'(raw.pop_back());
    end
    // escape most 00 00 0x runs, leave a few raw
    last2 = 16'hFFFF;
    foreach (raw[j]) begin
      if (last2 == 16'h0000 && raw[j] <= EPB && $urandom_range(0, 99) < 85) begin
        send_byte(EPB);
        last2 = {last2[7:0], EPB};
      end
      send_byte(raw[j]);
      last2 = {last2[7:0], raw[j]};
    end
  endtask

  task automatic stream_phase(input int words, input bit pause_mid);
    int  start;
    int  r;
    bit  paused;
    start = words_sent;
    paused = 0;
    while (words_sent - start < words) begin
      if (pause_mid && !paused && words_sent - start >= words / 2) begin
        paused = 1;
        wait_nals_done();
      end
      r = $urandom_range(0, 99);
      if (r < 84) send_unit(8);
      else if (r < 90) send_unit(40);
      else if (r < 95) repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      else send_eos();
    end
    send_eos();
    wait_nals_done();
  endtask

  task automatic cmp_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      m_tready <= 1'b0;
      sink_hold--;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin : nal_check
    nal_res_t want;
    if (!rst && s_tvalid && !s_tready) in_stalls++;
    if (!rst && m_tvalid && m_tready) begin
      nals_seen++;
      if (pending_nals.size() == 0) begin
        $error("NAL result with none pending: kind %0d type %0d", m_tuser, m_tdata[5:0]);
        mismatches++;
      end else begin
        want = pending_nals.pop_front();
        cmp_field("nal_kind", want.kind, m_tuser);
        cmp_field("nal_type", want.ntype, m_tdata[5:0]);
        cmp_field("frame_type", want.ft, m_tdata[7:6]);
        cmp_field("poc_lsb", want.poc, m_tdata[23:8]);
        cmp_field("payload_length", want.len, m_tdata[47:24]);
      end
    end
  end

  initial begin
    int i;
    nal_reset();
    dir_rows = '{
      '{1'b1, 8'hFF, 1'b0, NO_NAL},
      '{1'b0, 8'h55, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b0, NO_NAL},
      '{1'b0, 8'h40, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b0, NO_NAL},
      '{1'b1, 8'h00, 1'b1, '{hnhp_pkg::KIND_PSET, 6'd32, hnhp_pkg::FT_UNK, 16'd0, 24'd2}},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b0, NO_NAL},
      '{1'b0, 8'h26, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b0, NO_NAL},
      '{1'b0, 8'hAC, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h00, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b1, '{hnhp_pkg::KIND_SLICE, 6'd19, hnhp_pkg::FT_I, 16'd0, 24'd3}},
      '{1'b0, 8'h02, 1'b0, NO_NAL},
      '{1'b0, 8'h01, 1'b0, NO_NAL},
      '{1'b0, 8'hD7, 1'b0, NO_NAL},
      '{1'b0, 8'hF8, 1'b0, NO_NAL}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 23;
    sink_idle_pct = 84;
    for (i = 0; i < 25; i++) begin
      send_word(dir_rows[i].eos, dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);
    end
    // P slice, 8 POC bits all ones
    send_word(1'b1, 8'h5A, 1'b1,
              '{hnhp_pkg::KIND_SLICE, 6'd1, hnhp_pkg::FT_P, 16'hFF, 24'd4});
    wait_nals_done();

    write_cfg(hnhp_pkg::POC_BITS_MIN);
    stream_phase(180, 1'b1);

    src_idle_pct = 84;
    sink_idle_pct = 23;
    write_cfg(hnhp_pkg::POC_BITS_MAX);
    stream_phase(180, 1'b0);

    src_idle_pct = 0;
    sink_idle_pct = 0;
    write_cfg(5'd31);
    @(posedge clk);
    sink_hold = 300;
    @(negedge clk);
    repeat (16) send_unit(0);
    send_eos();
    wait_nals_done();

    write_cfg(5'd0);
    stream_phase(45, 1'b0);
    write_cfg(5'd3);
    stream_phase(45, 1'b0);
    write_cfg(5'd17);
    stream_phase(45, 1'b0);
    write_cfg(5'($urandom_range(5, 15)));
    stream_phase(45, 1'b0);

    $display("run: %0d stream words (%0d end-of-stream), %0d NAL results, %0d POC widths",
             words_sent, eos_sent, nals_seen, cfg_writes);
    $display("run: %0d input cycles held off by a full result queue", in_stalls);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/hnhp_pkg.sv
sv/hevc_annexb_nal_header_parser.sv
tb/tb.sv
